### sv/sparse_row_rank_index_unit_macros.svh
// assertion macros shared by the checker of the sparse row rank index unit
// expects signals named clk and rst in the scope of each use
`ifndef SPARSE_ROW_RANK_INDEX_UNIT_MACROS_SVH
`define SPARSE_ROW_RANK_INDEX_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SRRI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SRRI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/srri_pkg.sv
// shared constants, payload types, state type and helpers of the sparse row rank index
// depends on nothing
package srri_pkg;

  localparam int MAX_ROWS  = 1024;
  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = (MAX_ROWS + WORD_BITS - 1) / WORD_BITS;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int CNT_W     = $clog2(MAX_ROWS + 1);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int POP_W     = BIT_W + 1;

  // opcodes
  localparam logic [1:0] OP_MARK   = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_RANGE    = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [CNT_W-1:0] row_or_count;
  } cmd_t;

  typedef struct packed {
    logic             present;
    logic [ROW_W-1:0] physical_offset;
    logic [1:0]       status;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_FILL,
    ST_RANK,
    ST_DONE
  } state_t;

  function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] w);
    logic [POP_W-1:0] s;
    s = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      s = s + POP_W'(w[i]);
    end
    return s;
  endfunction

  // ones in the bit positions below b
  function automatic logic [WORD_BITS-1:0] low_mask(input logic [BIT_W-1:0] b);
    return ~({WORD_BITS{1'b1}} << b);
  endfunction

endpackage

### sv/sparse_row_rank_index_unit.sv
// top level of the sparse row rank index: presence bitmap memory, row counters and sequencer
// depends on srri_pkg
//
// row index of a sparse column. one command transaction gives exactly one result transaction.
// the presence bitmap sits in a 16 x 64 synchronous memory (one read and one write port, read
// data registered); a per-word valid flop cleared by reset makes unwritten words read as
// zero, so no clearing pass runs after reset. the block works on one command at a time and
// takes the next one while the previous result still waits in the output register.
// what each command does before the next one can be accepted:
//   out-of-range mark, sparse append, empty append, fast-path query, unused opcode: direct to done
//   mark row present: one read-modify-write of the word that holds the row
//   dense append: a read-modify-write of each bitmap word the run touches (1 to 16), in order
//   rank query: a word-a-cycle popcount sweep over the bitmap memory, from word 0 up to the
//     word that holds the row (0 to 15)
// res_stall on the previous result can delay the next acceptance. the result register parts
// the two sides; res_valid is registered. allow_sparse is written through cfg_we/cfg_data.
module sparse_row_rank_index_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_data,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  srri_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output srri_pkg::res_t res
);
  import srri_pkg::*;

  // control state
  state_t           state, state_next;
  logic             allow_sparse;
  logic [CNT_W-1:0] logical_rows, logical_next;
  logic [CNT_W-1:0] stored_rows, stored_next;

  // bitmap memory and per-word valid flops
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] word_valid;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_valid;
  logic                 rd_en;
  logic [WIDX_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [WIDX_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] word;

  // per-command working registers
  logic [ROW_W-1:0]  op_row, op_row_next;     // marked or queried row, first row of a fill
  logic [ROW_W-1:0]  end_row, end_row_next;   // last row of a fill
  logic [WIDX_W-1:0] widx, widx_next;         // word cursor of a sweep
  logic [CNT_W-1:0]  rank_sum, rank_sum_next;
  res_t              result, result_next;
  logic              load_res;

  // decode of the incoming command
  logic             accept;
  logic [CNT_W-1:0] arg;
  logic [ROW_W-1:0] arg_row;
  logic [CNT_W-1:0] room;
  logic [CNT_W-1:0] run;
  logic [CNT_W-1:0] run_end;
  logic             arg_past_cap;
  logic             arg_past_end;
  logic             dense;

  // word and bit positions of the working rows
  logic [WIDX_W-1:0]    op_word, last_word;
  logic [BIT_W-1:0]     op_bit, last_bit;
  logic [BIT_W-1:0]     lo_off, hi_off;
  logic [WORD_BITS-1:0] fill_mask;
  logic [WORD_BITS-1:0] pop_in;
  logic [POP_W-1:0]     pop_cnt;
  logic                 at_row_word;

  assign accept       = cmd_valid && !cmd_stall;
  assign arg          = cmd.row_or_count;
  assign arg_row      = arg[ROW_W-1:0];
  assign room         = CNT_W'(MAX_ROWS) - logical_rows;
  assign run          = (arg > room) ? room : arg;   // saturate at capacity
  assign run_end      = logical_rows + run;
  assign arg_past_cap = (arg >= CNT_W'(MAX_ROWS));
  assign arg_past_end = (arg >= logical_rows);
  assign dense        = (logical_rows == stored_rows);

  assign op_word   = WIDX_W'(op_row >> BIT_W);
  assign op_bit    = op_row[BIT_W-1:0];
  assign last_word = WIDX_W'(end_row >> BIT_W);
  assign last_bit  = end_row[BIT_W-1:0];

  // unwritten words read as zero
  assign word = rd_valid ? rd_data : '0;

  // fill mask: rows op_row..end_row that fall in the word under the cursor
  assign lo_off    = (widx == op_word) ? op_bit : '0;
  assign hi_off    = (widx == last_word) ? last_bit : '1;
  assign fill_mask = ~low_mask(lo_off)
                   & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_off));

  // rank sweep: whole words below the row, then the part of its word below it
  assign at_row_word = (widx == op_word);
  assign pop_in      = at_row_word ? (word & low_mask(op_bit)) : word;
  assign pop_cnt     = popcount(pop_in);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd.opcode)
            OP_MARK:   state_next = arg_past_cap ? ST_DONE : ST_MARK;
            OP_APPEND: state_next = (allow_sparse || run == '0) ? ST_DONE : ST_FILL;
            OP_QUERY:  state_next = (arg_past_end || dense) ? ST_DONE : ST_RANK;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_MARK: state_next = ST_DONE;
      ST_FILL: state_next = (widx == last_word) ? ST_DONE : ST_FILL;
      ST_RANK: state_next = at_row_word ? ST_DONE : ST_RANK;
      ST_DONE: state_next = (!res_valid || !res_stall) ? ST_IDLE : ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath
  // the sequencer never has a write and a read of the same word in flight: a mark writes
  // only its own word, a fill reads the next word while writing the current one, and a new
  // command is read only after the previous one has left through the done state
  always_comb begin
    cmd_stall     = (state != ST_IDLE);
    rd_en         = 1'b0;
    rd_addr       = widx;
    wr_en         = 1'b0;
    wr_addr       = widx;
    wr_data       = word | fill_mask;
    load_res      = 1'b0;
    logical_next  = logical_rows;
    stored_next   = stored_rows;
    op_row_next   = op_row;
    end_row_next  = end_row;
    widx_next     = widx;
    rank_sum_next = rank_sum;
    result_next   = result;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          result_next   = '0;
          result_next.status = STAT_OK;
          op_row_next   = arg_row;
          widx_next     = '0;
          rank_sum_next = '0;
          case (cmd.opcode)
            OP_MARK: begin
              if (arg_past_cap) begin
                result_next.status = STAT_OVERFLOW;
              end else begin
                rd_en   = 1'b1;
                rd_addr = WIDX_W'(arg_row >> BIT_W);
              end
            end
            OP_APPEND: begin
              if (arg > room) begin
                result_next.status = STAT_OVERFLOW;
              end
              logical_next = run_end;
              if (!allow_sparse) begin
                // rows at or past the end are never set, so every appended row is new
                stored_next   = stored_rows + run;
                op_row_next   = logical_rows[ROW_W-1:0];
                end_row_next  = ROW_W'(run_end - CNT_W'(1));
                widx_next     = WIDX_W'(logical_rows[ROW_W-1:0] >> BIT_W);
                rd_en         = (run != '0);
                rd_addr       = WIDX_W'(logical_rows[ROW_W-1:0] >> BIT_W);
              end
            end
            OP_QUERY: begin
              if (arg_past_end) begin
                result_next.status = allow_sparse ? STAT_OK : STAT_RANGE;
              end else if (dense) begin
                result_next.present         = 1'b1;
                result_next.physical_offset = arg_row;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
              end
            end
            default: begin
              result_next = '0;
            end
          endcase
        end
      end
      ST_MARK: begin
        if (!word[op_bit]) begin
          wr_en       = 1'b1;
          wr_addr     = op_word;
          wr_data     = word | ~({WORD_BITS{1'b1}} << 1) << op_bit;
          stored_next = stored_rows + CNT_W'(1);
        end
        // marking beyond the end extends the column
        if (CNT_W'(op_row) >= logical_rows) begin
          logical_next = CNT_W'(op_row) + CNT_W'(1);
        end
      end
      ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = widx;
        wr_data = word | fill_mask;
        if (widx != last_word) begin
          widx_next = widx + WIDX_W'(1);
          rd_en     = 1'b1;
          rd_addr   = widx + WIDX_W'(1);
        end
      end
      ST_RANK: begin
        if (at_row_word) begin
          result_next.present         = word[op_bit];
          result_next.physical_offset = word[op_bit]
                                      ? ROW_W'(rank_sum + CNT_W'(pop_cnt)) : '0;
        end else begin
          rank_sum_next = rank_sum + CNT_W'(pop_cnt);
          widx_next     = widx + WIDX_W'(1);
          rd_en         = 1'b1;
          rd_addr       = widx + WIDX_W'(1);
        end
      end
      ST_DONE: begin
        load_res = !res_valid || !res_stall;
      end
      default: begin
        load_res = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      allow_sparse <= 1'b1;
      logical_rows <= '0;
      stored_rows  <= '0;
      word_valid   <= '0;
      res_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      logical_rows <= logical_next;
      stored_rows  <= stored_next;
      if (cfg_we) begin
        allow_sparse <= cfg_data;
      end
      if (wr_en) begin
        word_valid[wr_addr] <= 1'b1;
      end
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    op_row   <= op_row_next;
    end_row  <= end_row_next;
    widx     <= widx_next;
    rank_sum <= rank_sum_next;
    result   <= result_next;
    if (load_res) begin
      res <= result;
    end
  end

  // bitmap memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= word_valid[rd_addr];
    end
  end

endmodule

### sv/srri_checker.sv
// port-level assertions of the sparse row rank index unit and the bind that attaches them
// depends on srri_pkg and sparse_row_rank_index_unit_macros.svh
`include "sparse_row_rank_index_unit_macros.svh"

module srri_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input logic           res_valid,
  input logic           res_stall,
  input srri_pkg::res_t res
);
  import srri_pkg::*;

  `SRRI_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")
  `SRRI_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && !cmd_stall, cmd_stall, "second command taken while busy")
  `SRRI_ASSERT_SAME(a_present_ok, res_valid && res.present, res.status == STAT_OK, "present row with error status")
  `SRRI_ASSERT_SAME(a_absent_zero, res_valid && !res.present, res.physical_offset == '0, "absent row with nonzero offset")

endmodule

bind sparse_row_rank_index_unit srri_checker u_srri_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

### test/tb_top.sv
// self-checking testbench for sparse_row_rank_index_unit: directed and random row commands
// depends on srri_pkg and sparse_row_rank_index_unit
module tb_top;
  import srri_pkg::*;

  // opcode that the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // cycles with no transaction on either side before the run is declared hung
  localparam int QUIET_LIMIT = 3000;
  // cycles to wait after the last expected result for a stray one
  localparam int TAIL_CYCLES = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd_word = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_word;

  // mirror of the block state, advanced once per accepted command transaction
  logic [MAX_ROWS-1:0] row_present = '0;
  int unsigned logical_cnt = 0;
  int unsigned stored_cnt = 0;
  bit sparse_ok = 1'b1;

  res_t pending_results[$];
  res_t want_res;
  int mismatch_cnt = 0;
  int quiet_cycles = 0;

  // idle odds in percent for each side, and a long receiver hold in cycles
  int snd_pct = 0;
  int rcv_pct = 0;
  int hold_left = 0;

  sparse_row_rank_index_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd_word),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res_word)
  );

  always #5 clk = ~clk;

  // expected result of one command, updating the mirrored bitmap and counters
  function automatic res_t predict_row_index(input cmd_t c);
    res_t r;
    int unsigned arg;
    int unsigned room;
    int unsigned run;
    int unsigned rank;
    r = '0;
    arg = c.row_or_count;
    case (c.opcode)
      OP_MARK: begin
        if (arg >= MAX_ROWS) begin
          r.status = STAT_OVERFLOW;
        end else begin
          if (!row_present[arg]) begin
            row_present[arg] = 1'b1;
            stored_cnt++;
          end
          if (arg >= logical_cnt) logical_cnt = arg + 1;
        end
      end
      OP_APPEND: begin
        room = MAX_ROWS - logical_cnt;
        run = arg;
        if (run > room) begin
          run = room;
          r.status = STAT_OVERFLOW;
        end
        // dense mode appends present rows right after the logical end
        if (!sparse_ok) begin
          for (int i = 0; i < run; i++) begin
            if (!row_present[logical_cnt + i]) begin
              row_present[logical_cnt + i] = 1'b1;
              stored_cnt++;
            end
          end
        end
        logical_cnt += run;
      end
      OP_QUERY: begin
        if (arg >= logical_cnt) begin
          r.status = sparse_ok ? STAT_OK : STAT_RANGE;
        end else if (logical_cnt == stored_cnt) begin
          // fully populated column: offset is the row itself
          r.present = 1'b1;
          r.physical_offset = arg[ROW_W-1:0];
        end else if (row_present[arg]) begin
          rank = 0;
          for (int i = 0; i < arg; i++) rank += row_present[i];
          r.present = 1'b1;
          r.physical_offset = rank[ROW_W-1:0];
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic cmd_t make_cmd(input logic [1:0] op, input int unsigned arg);
    cmd_t c;
    c.opcode = op;
    c.row_or_count = arg[CNT_W-1:0];
    return c;
  endfunction

  function automatic int unsigned min_u(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // random command that mostly stays near the logical end so the column grows slowly
  function automatic cmd_t random_row_cmd();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30)
      return make_cmd(OP_MARK, $urandom_range(0, min_u(logical_cnt + 3, MAX_ROWS - 1)));
    else if (pick < 45)
      return make_cmd(OP_APPEND, $urandom_range(0, 8));
    else if (pick < 83)
      return make_cmd(OP_QUERY, $urandom_range(0, logical_cnt + 2));
    else if (pick < 88)
      // rows past capacity exercise the top address bit
      return make_cmd($urandom_range(1) ? OP_QUERY : OP_MARK, $urandom_range(1024, 2047));
    else if (pick < 91)
      return make_cmd(OP_UNUSED, $urandom_range(0, 2047));
    else if (pick < 94)
      return make_cmd(OP_MARK,
                      $urandom_range(min_u(logical_cnt, MAX_ROWS - 1),
                                     min_u(logical_cnt + 64, MAX_ROWS - 1)));
    else if (pick < 96)
      return make_cmd(OP_APPEND, $urandom_range(9, 64));
    else
      return make_cmd(OP_QUERY, $urandom_range(0, 2047));
  endfunction

  // offer one command transaction, with random idle cycles ahead of it
  task automatic send_cmd(input cmd_t c);
    while ($urandom_range(99) < snd_pct) begin
      @(negedge clk);
      cmd_valid = 1'b0;
    end
    @(negedge clk);
    cmd_valid = 1'b1;
    cmd_word = c;
    do @(posedge clk); while (cmd_stall);
    pending_results.insert(pending_results.size(), predict_row_index(c));
  endtask

  // stop offering and wait until every expected result has come back
  task automatic wait_drained();
    @(negedge clk);
    cmd_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // allow_sparse write, only with the block idle
  task automatic set_sparse_mode(input bit mode);
    wait_drained();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = mode;
    @(negedge clk);
    cfg_we = 1'b0;
    sparse_ok = mode;
  endtask

  // receiver: long hold when asked, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_stall = 1'b1;
      hold_left--;
    end else begin
      res_stall = ($urandom_range(99) < rcv_pct);
    end
  end

  // result checker, one expectation per result transaction in order
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result transaction: present %0d offset %0d status %0d",
                 $time, res_word.present, res_word.physical_offset, res_word.status);
        mismatch_cnt++;
      end else begin
        want_res = pending_results.pop_front();
        if (res_word.present !== want_res.present) begin
          $display("%0t present mismatch: expected %0d, actual %0d",
                   $time, want_res.present, res_word.present);
          mismatch_cnt++;
        end
        if (res_word.physical_offset !== want_res.physical_offset) begin
          $display("%0t physical_offset mismatch: expected %0d, actual %0d",
                   $time, want_res.physical_offset, res_word.physical_offset);
          mismatch_cnt++;
        end
        if (res_word.status !== want_res.status) begin
          $display("%0t status mismatch: expected %0d, actual %0d",
                   $time, want_res.status, res_word.status);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // extremes of both fields, every opcode and the corner cases of mark, append and query
  task automatic test_directed();
    snd_pct = 20;
    rcv_pct = 20;
    send_cmd(make_cmd(OP_QUERY, 0));      // empty column, past the end in sparse mode
    send_cmd(make_cmd(OP_APPEND, 0));     // empty run
    send_cmd(make_cmd(OP_MARK, 3));       // mark beyond the end leaves a gap of absent rows
    send_cmd(make_cmd(OP_MARK, 3));       // row already present
    send_cmd(make_cmd(OP_QUERY, 3));
    send_cmd(make_cmd(OP_QUERY, 1));      // absent row inside the column
    send_cmd(make_cmd(OP_QUERY, 4));
    send_cmd(make_cmd(OP_MARK, 1024));    // past capacity
    send_cmd(make_cmd(OP_MARK, 2047));
    send_cmd(make_cmd(OP_UNUSED, 2047));
    send_cmd(make_cmd(OP_APPEND, 10));    // sparse run, absent rows
    send_cmd(make_cmd(OP_QUERY, 2047));
    set_sparse_mode(1'b0);
    send_cmd(make_cmd(OP_QUERY, 14));     // past the end in dense mode
    send_cmd(make_cmd(OP_QUERY, 2047));
    send_cmd(make_cmd(OP_APPEND, 6));     // dense run appended to a sparse column
    send_cmd(make_cmd(OP_QUERY, 16));
    send_cmd(make_cmd(OP_QUERY, 0));
    send_cmd(make_cmd(OP_UNUSED, 0));
  endtask

  // fill every gap so stored equals logical, then hit the fully populated query path
  task automatic test_dense_fill();
    int unsigned top;
    top = logical_cnt;
    for (int unsigned r = 0; r < top; r++) begin
      if (!row_present[r]) send_cmd(make_cmd(OP_MARK, r));
    end
    send_cmd(make_cmd(OP_QUERY, 0));
    send_cmd(make_cmd(OP_QUERY, logical_cnt - 1));
    send_cmd(make_cmd(OP_APPEND, 5));     // dense mode keeps the column full
    repeat (4) send_cmd(make_cmd(OP_QUERY, $urandom_range(0, logical_cnt - 1)));
    send_cmd(make_cmd(OP_QUERY, logical_cnt));
  endtask

  // receiver holds off while the sender keeps offering, then the sender pauses
  task automatic test_backpressure();
    set_sparse_mode(1'b1);
    snd_pct = 0;
    rcv_pct = 0;
    hold_left = 300;
    repeat (14) send_cmd(random_row_cmd());
    // pause until the block has handed back everything
    wait_drained();
    repeat (10) send_cmd(random_row_cmd());
  endtask

  task automatic test_random(input int count, input int s_pct, input int r_pct,
                             input bit mode);
    set_sparse_mode(mode);
    snd_pct = s_pct;
    rcv_pct = r_pct;
    repeat (count) send_cmd(random_row_cmd());
  endtask

  // saturate the logical count in both modes and sweep ranks across the whole bitmap
  task automatic test_capacity();
    set_sparse_mode(1'b0);
    snd_pct = 10;
    rcv_pct = 10;
    send_cmd(make_cmd(OP_APPEND, 2047));  // dense run clipped at capacity
    send_cmd(make_cmd(OP_QUERY, 1023));
    send_cmd(make_cmd(OP_QUERY, 0));
    send_cmd(make_cmd(OP_MARK, 1023));
    send_cmd(make_cmd(OP_APPEND, 1));
    send_cmd(make_cmd(OP_QUERY, 1024));
    set_sparse_mode(1'b1);
    send_cmd(make_cmd(OP_QUERY, 1024));
    send_cmd(make_cmd(OP_APPEND, 2047));
    repeat (4) send_cmd(make_cmd(OP_QUERY, $urandom_range(0, 1023)));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_dense_fill();
    test_backpressure();
    test_random(210, 32, 54, 1'b1);
    test_random(210, 54, 32, 1'b0);
    test_random(210, 0, 0, 1'b1);
    test_capacity();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
